// ===== sv/iirdf2_pkg.sv =====
// ----------------------------------------------------------------------------
// Direct-form-II IIR filter package
// Shared field widths, request and response layouts, codes and control
// structures of the filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

   // Default maximum pole and zero counts; they size the coefficient stores.
   localparam int DEF_MAX_POLES = 64;
   localparam int DEF_MAX_ZEROS = 64;

   // Fixed field widths.
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int STATE_W     = 40;
   localparam int FRAC_W      = 24;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 8;

   // Request function codes.
   localparam logic FUNC_FILTER = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLE_COUNT = 8'd1;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       coef_is_pole;
      logic [6:0]                 coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [COUNT_W-1:0]     data;
   } csr_payload_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_POLE,
      SEQ_POLE_DRAIN,
      SEQ_ZERO,
      SEQ_ZERO_DRAIN
   } seq_state_type;

   // One multiply-accumulate step as it travels down the pipeline.
   typedef struct packed {
      logic valid;
      logic neg;
      logic is_pole;
      logic use_w;
   } tap_type;

   typedef struct packed {
      tap_type                    tap;
      logic                       acc_load;
      logic signed [SAMPLE_W-1:0] acc_base;
      logic                       capture_w;
   } mac_ctrl_type;

   typedef struct packed {
      logic idle;
      logic finish;
      logic dl_we;
   } seq_status_type;

endpackage

// ===== sv/iirdf2_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface iirdf2_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/iirdf2_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module iirdf2_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/iirdf2_mac.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate pipeline
// Coefficient times state word in two partial products, exact accumulation,
// and rounding with saturation of the accumulator.
// ----------------------------------------------------------------------------
module iirdf2_mac #(
   parameter int MAX_TAPS = 65
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iirdf2_pkg::mac_ctrl_type               ctrl,
   input  logic signed [iirdf2_pkg::COEF_W-1:0]   a_coef,
   input  logic signed [iirdf2_pkg::COEF_W-1:0]   b_coef,
   input  logic [iirdf2_pkg::STATE_W-1:0]         delay_q,
   output logic [iirdf2_pkg::STATE_W-1:0]         w_out,
   output logic signed [iirdf2_pkg::SAMPLE_W-1:0] y_out,
   output logic                                   busy
);
   import iirdf2_pkg::*;

   localparam int SPLIT  = STATE_W / 2;
   localparam int PROD_W = COEF_W + STATE_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 2) + 1;

   tap_type tap1_ff, tap1_in, tap2_ff, tap2_in, tap3_ff, tap3_in;

   logic signed [COEF_W-1:0]              coef;
   logic [STATE_W-1:0]                    operand;
   logic signed [COEF_W+SPLIT:0]          p_lo_ff, p_lo_in;
   logic signed [COEF_W+STATE_W-SPLIT-1:0] p_hi_ff, p_hi_in;
   logic signed [PROD_W-1:0]              prod_ff, prod_in;
   logic signed [ACC_W-1:0]               acc_ff, acc_in;
   logic signed [ACC_W-1:0]               rounded, shifted;
   logic [STATE_W-1:0]                    w_ff, w_in, w_sat;
   logic signed [SAMPLE_W-1:0]            y_sat;

   // Stage one: operands arrive from the stores, two partial products.
   always_comb begin
      tap1_in = ctrl.tap;
      tap2_in = tap1_ff;
      tap3_in = tap2_ff;
      operand = tap1_ff.use_w ? w_ff : delay_q;
      coef    = tap1_ff.is_pole ? a_coef : b_coef;
      p_lo_in = coef * $signed({1'b0, operand[SPLIT-1:0]});
      p_hi_in = coef * $signed(operand[STATE_W-1:SPLIT]);
   end

   // Stage two: combine the partial products.
   assign prod_in = (PROD_W'(p_hi_ff) <<< SPLIT) + PROD_W'(p_lo_ff);

   // Stage three: accumulate.
   always_comb begin
      if (ctrl.acc_load) begin
         acc_in = ACC_W'(ctrl.acc_base) <<< FRAC_W;
      end else if (tap3_ff.valid) begin
         acc_in = tap3_ff.neg ? (acc_ff - ACC_W'(prod_ff)) : (acc_ff + ACC_W'(prod_ff));
      end else begin
         acc_in = acc_ff;
      end
   end

   // Round half up, then clamp to the state and sample ranges.
   always_comb begin
      rounded = acc_ff + (ACC_W'(1) <<< (FRAC_W - 1));
      shifted = rounded >>> FRAC_W;
      if (shifted[ACC_W-1:STATE_W-1] == '0 || shifted[ACC_W-1:STATE_W-1] == '1) begin
         w_sat = shifted[STATE_W-1:0];
      end else begin
         w_sat = {shifted[ACC_W-1], {(STATE_W - 1){~shifted[ACC_W-1]}}};
      end
      if (shifted[ACC_W-1:SAMPLE_W-1] == '0 || shifted[ACC_W-1:SAMPLE_W-1] == '1) begin
         y_sat = shifted[SAMPLE_W-1:0];
      end else begin
         y_sat = {shifted[ACC_W-1], {(SAMPLE_W - 1){~shifted[ACC_W-1]}}};
      end
      w_in = ctrl.capture_w ? w_sat : w_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap1_ff <= '0;
         tap2_ff <= '0;
         tap3_ff <= '0;
      end else begin
         tap1_ff <= tap1_in;
         tap2_ff <= tap2_in;
         tap3_ff <= tap3_in;
      end
   end

   always_ff @(posedge clock) begin
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      w_ff    <= w_in;
   end

   assign w_out = w_ff;
   assign y_out = y_sat;
   assign busy  = tap1_ff.valid | tap2_ff.valid | tap3_ff.valid;
endmodule

// ===== sv/iirdf2_seq.sv =====
// ----------------------------------------------------------------------------
// Filter sequencer
// Walks the pole and zero taps, generates store addresses and keeps the
// circular write position of the delay line.
// ----------------------------------------------------------------------------
module iirdf2_seq #(
   parameter int  MAX_POLES = 64,
   parameter int  MAX_ZEROS = 64,
   localparam int DLINE     = (MAX_ZEROS > MAX_POLES) ? MAX_ZEROS : MAX_POLES,
   localparam int AAW       = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1,
   localparam int BAW       = $clog2(MAX_ZEROS + 1),
   localparam int DAW       = (DLINE > 1) ? $clog2(DLINE) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_in,
   input  logic                                   cfg_clear,
   input  logic [iirdf2_pkg::COUNT_W-1:0]         zero_count,
   input  logic [iirdf2_pkg::COUNT_W-1:0]         pole_count,
   input  logic                                   busy,
   input  logic                                   out_free,
   output logic [AAW-1:0]                         a_raddr,
   output logic [BAW-1:0]                         b_raddr,
   output logic [DAW-1:0]                         d_raddr,
   output logic [DAW-1:0]                         d_waddr,
   output iirdf2_pkg::mac_ctrl_type               mac_ctrl,
   output iirdf2_pkg::seq_status_type             status
);
   import iirdf2_pkg::*;

   localparam int NB_W  = $clog2(MAX_ZEROS + 2);
   localparam int NA_W  = $clog2(MAX_POLES + 1);
   localparam int CNT_W = (NB_W > NA_W) ? NB_W : NA_W;

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DAW-1:0]   pos_ff, pos_in;
   logic [DAW-1:0]   wp_ff, wp_in;

   logic [CNT_W-1:0] nb, na, nb_less, len;
   logic [DAW-1:0]   last_pos, wp_eff, start_pos, pos_dec, wp_next;
   logic             pole_issue, zero_issue, pole_done, zero_done;

   // Effective counts and delay line length.
   always_comb begin
      if (zero_count == '0) begin
         nb = CNT_W'(1);
      end else if (32'(zero_count) > MAX_ZEROS + 1) begin
         nb = CNT_W'(MAX_ZEROS + 1);
      end else begin
         nb = CNT_W'(zero_count);
      end
      if (32'(pole_count) > MAX_POLES) begin
         na = CNT_W'(MAX_POLES);
      end else begin
         na = CNT_W'(pole_count);
      end
      nb_less   = nb - CNT_W'(1);
      len       = (nb_less > na) ? nb_less : na;
      last_pos  = DAW'(len - CNT_W'(1));
      wp_eff    = (CNT_W'(wp_ff) >= len) ? '0 : wp_ff;
      start_pos = (wp_eff == '0) ? last_pos : (wp_eff - DAW'(1));
      pos_dec   = (pos_ff == '0) ? last_pos : (pos_ff - DAW'(1));
      wp_next   = (wp_eff == last_pos) ? '0 : (wp_eff + DAW'(1));
      pole_issue = (state_ff == SEQ_POLE) && (cnt_ff != na);
      zero_issue = (state_ff == SEQ_ZERO) && (cnt_ff != nb);
      pole_done  = (state_ff == SEQ_POLE_DRAIN) && !busy;
      zero_done  = (state_ff == SEQ_ZERO_DRAIN) && !busy && out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_POLE;
            end
         end
         SEQ_POLE: begin
            if (cnt_ff == na) begin
               state_in = SEQ_POLE_DRAIN;
            end
         end
         SEQ_POLE_DRAIN: begin
            if (!busy) begin
               state_in = SEQ_ZERO;
            end
         end
         SEQ_ZERO: begin
            if (cnt_ff == nb) begin
               state_in = SEQ_ZERO_DRAIN;
            end
         end
         SEQ_ZERO_DRAIN: begin
            if (zero_done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Counters and write position.
   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      wp_in  = wp_ff;
      if (start && state_ff == SEQ_IDLE) begin
         cnt_in = '0;
         pos_in = start_pos;
      end else if (pole_issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
         pos_in = pos_dec;
      end else if (pole_done) begin
         cnt_in = '0;
         pos_in = start_pos;
      end else if (zero_issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff != '0) begin
            pos_in = pos_dec;
         end
      end
      if (cfg_clear) begin
         wp_in = '0;
      end else if (zero_done && len != '0) begin
         wp_in = wp_next;
      end
   end

   // Outputs.
   always_comb begin
      a_raddr             = AAW'(cnt_ff);
      b_raddr             = BAW'(cnt_ff);
      d_raddr             = pos_ff;
      d_waddr             = wp_eff;
      mac_ctrl.tap.valid   = pole_issue || zero_issue;
      mac_ctrl.tap.neg     = (state_ff == SEQ_POLE);
      mac_ctrl.tap.is_pole = (state_ff == SEQ_POLE);
      mac_ctrl.tap.use_w   = (state_ff == SEQ_ZERO) && (cnt_ff == '0);
      mac_ctrl.acc_load    = (start && state_ff == SEQ_IDLE) || pole_done;
      mac_ctrl.acc_base    = (state_ff == SEQ_IDLE) ? sample_in : '0;
      mac_ctrl.capture_w   = pole_done;
      status.idle          = (state_ff == SEQ_IDLE);
      status.finish        = zero_done;
      status.dl_we         = zero_done && (len != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         wp_ff    <= wp_in;
      end
   end
endmodule

// ===== sv/iir_direct_form_two_filter.sv =====
// ----------------------------------------------------------------------------
// Direct-form-II IIR filter
// Loadable-coefficient IIR filter with a shared multiply-accumulate unit
// and the delay line and coefficients held in synchronous memories.
// ----------------------------------------------------------------------------
// The single multiply-accumulate pipeline takes one tap per cycle, fed
// through the one read port of the delay-line memory, and it is drained
// between the pole sum and the output sum because the output sum needs the
// new state word first. A response that cannot yet enter the output
// register, because the previous one has not been taken, holds the
// sequencer until that register frees up.
// A coefficient-load request gives no response.
// One request is worked on at a time; a new request is accepted as soon as
// the sequencer is idle, even while the previous response still waits in the
// output register. The delay line and all coefficients read as zero after
// reset, and a write to the zero-count or pole-count register clears the
// delay line again.
module iir_direct_form_two_filter #(
   parameter int MAX_POLES = iirdf2_pkg::DEF_MAX_POLES,
   parameter int MAX_ZEROS = iirdf2_pkg::DEF_MAX_ZEROS
) (
   input logic             clock,
   input logic             reset,
   iirdf2_stream_if.sink   req_if,
   iirdf2_stream_if.source rsp_if,
   iirdf2_stream_if.sink   csr_if
);
   import iirdf2_pkg::*;

   localparam int DLINE = (MAX_ZEROS > MAX_POLES) ? MAX_ZEROS : MAX_POLES;
   localparam int AAW   = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
   localparam int BAW   = $clog2(MAX_ZEROS + 1);
   localparam int DAW   = (DLINE > 1) ? $clog2(DLINE) : 1;
   localparam int TAPS  = (MAX_ZEROS + 1 > MAX_POLES) ? (MAX_ZEROS + 1) : MAX_POLES;

   // Configuration registers.
   logic [COUNT_W-1:0] zero_count_ff, zero_count_in;
   logic [COUNT_W-1:0] pole_count_ff, pole_count_in;
   logic               csr_write, cfg_clear;

   // Request handshake.
   logic req_accept, start, coef_load;

   // Store ports.
   logic             a_we, b_we;
   logic [AAW-1:0]   a_waddr, a_raddr;
   logic [BAW-1:0]   b_waddr, b_raddr;
   logic [DAW-1:0]   d_raddr, d_waddr;
   logic [COEF_W-1:0]  a_rdata, b_rdata;
   logic [STATE_W-1:0] d_rdata;

   // Valid bits: an entry that has not been written since reset (or, for the
   // delay line, since the last count register write) reads as zero.
   logic [MAX_POLES-1:0]   a_valid_ff, a_valid_in;
   logic [MAX_ZEROS:0]     b_valid_ff, b_valid_in;
   logic [DLINE-1:0]       d_valid_ff, d_valid_in;
   logic                   a_vld_q_ff, a_vld_q_in;
   logic                   b_vld_q_ff, b_vld_q_in;
   logic                   d_vld_q_ff, d_vld_q_in;

   logic signed [COEF_W-1:0] a_coef, b_coef;
   logic [STATE_W-1:0]       delay_q;

   mac_ctrl_type   mac_ctrl;
   seq_status_type status;
   logic           busy, out_free;
   logic [STATE_W-1:0]         w_value;
   logic signed [SAMPLE_W-1:0] y_value;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_out_ff, sample_out_in;

   // Registers are always writable; the user must reconfigure the block only while idle, the block does not enforce it.
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   always_comb begin
      zero_count_in = zero_count_ff;
      pole_count_in = pole_count_ff;
      cfg_clear     = 1'b0;
      if (csr_write) begin
         case (csr_if.payload.index)
            CSR_ZERO_COUNT: begin
               zero_count_in = csr_if.payload.data;
               cfg_clear     = 1'b1;
            end
            CSR_POLE_COUNT: begin
               pole_count_in = csr_if.payload.data;
               cfg_clear     = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   // A request is taken whenever the sequencer is idle. Coefficient loads go
   // straight into their store; out-of-range indexes are dropped.
   assign req_if.ready = status.idle;
   assign req_accept   = req_if.valid && status.idle;
   assign start        = req_accept && (req_if.payload.func == FUNC_FILTER);
   assign coef_load    = req_accept && (req_if.payload.func == FUNC_LOAD);

   assign a_we    = coef_load && req_if.payload.coef_is_pole
                    && (32'(req_if.payload.coef_index) < MAX_POLES);
   assign b_we    = coef_load && !req_if.payload.coef_is_pole
                    && (32'(req_if.payload.coef_index) <= MAX_ZEROS);
   assign a_waddr = AAW'(req_if.payload.coef_index);
   assign b_waddr = BAW'(req_if.payload.coef_index);

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      d_valid_in = d_valid_ff;
      if (a_we) begin
         a_valid_in[a_waddr] = 1'b1;
      end
      if (b_we) begin
         b_valid_in[b_waddr] = 1'b1;
      end
      if (cfg_clear) begin
         d_valid_in = '0;
      end else if (status.dl_we) begin
         d_valid_in[d_waddr] = 1'b1;
      end
      a_vld_q_in = a_valid_ff[a_raddr];
      b_vld_q_in = b_valid_ff[b_raddr];
      d_vld_q_in = d_valid_ff[d_raddr];
   end

   assign a_coef  = a_vld_q_ff ? $signed(a_rdata) : '0;
   assign b_coef  = b_vld_q_ff ? $signed(b_rdata) : '0;
   assign delay_q = d_vld_q_ff ? d_rdata : '0;

   iirdf2_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_POLES)
   ) u_pole_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (req_if.payload.coef_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   iirdf2_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_ZEROS + 1)
   ) u_zero_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (req_if.payload.coef_value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   iirdf2_ram #(
      .WIDTH (STATE_W),
      .DEPTH (DLINE)
   ) u_delay_ram (
      .clock (clock),
      .we    (status.dl_we),
      .waddr (d_waddr),
      .wdata (w_value),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   iirdf2_seq #(
      .MAX_POLES (MAX_POLES),
      .MAX_ZEROS (MAX_ZEROS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sample_in  (req_if.payload.sample_in),
      .cfg_clear  (cfg_clear),
      .zero_count (zero_count_ff),
      .pole_count (pole_count_ff),
      .busy       (busy),
      .out_free   (out_free),
      .a_raddr    (a_raddr),
      .b_raddr    (b_raddr),
      .d_raddr    (d_raddr),
      .d_waddr    (d_waddr),
      .mac_ctrl   (mac_ctrl),
      .status     (status)
   );

   iirdf2_mac #(
      .MAX_TAPS (TAPS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_coef  (a_coef),
      .b_coef  (b_coef),
      .delay_q (delay_q),
      .w_out   (w_value),
      .y_out   (y_value),
      .busy    (busy)
   );

   // The output register frees up in the same cycle its response is taken.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      sample_out_in = sample_out_ff;
      if (status.finish) begin
         rsp_valid_in  = 1'b1;
         sample_out_in = y_value;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.payload.sample_out = sample_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_count_ff <= COUNT_W'(1);
         pole_count_ff <= '0;
         a_valid_ff    <= '0;
         b_valid_ff    <= '0;
         d_valid_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         zero_count_ff <= zero_count_in;
         pole_count_ff <= pole_count_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         d_valid_ff    <= d_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_vld_q_ff    <= a_vld_q_in;
      b_vld_q_ff    <= b_vld_q_in;
      d_vld_q_ff    <= d_vld_q_in;
      sample_out_ff <= sample_out_in;
   end
endmodule
